@@ hw/rtl/ccr_pkg.sv @@
// Package for the circle collision resolver: widths, contact codes and the
// queue entry type passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccr_pkg;

   localparam int COORD_W     = 32;
   localparam int RAD_W       = 24;
   localparam int RSUM_W      = 25;
   localparam int MAG_W       = 26;
   localparam int D2_W        = 52;
   localparam int ROOT_W      = 26;
   localparam int NUM_W       = 43;
   localparam int QUO_W       = 17;
   localparam int NORM_W      = 18;
   localparam int OVL_W       = 27;
   localparam int CONT_W      = 26;
   localparam int TINY_DIST   = 7;
   localparam int Q_ONE       = 65536;
   localparam int QUEUE_DEPTH = 4;
   localparam int SQRT_STEPS  = 26;
   localparam int DIV_STEPS   = 17;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_SOLID   = 2'd1,
      KIND_TRIGGER = 2'd2
   } kind_type;

   // classified pair, as queued for the back end
   typedef struct packed {
      kind_type                   kind;
      logic signed [COORD_W-1:0]  a_x;
      logic signed [COORD_W-1:0]  a_y;
      logic signed [COORD_W-1:0]  b_x;
      logic signed [COORD_W-1:0]  b_y;
      logic [RAD_W-1:0]           b_radius;
      logic [RSUM_W-1:0]          rsum;
      logic                       neg_x;
      logic                       neg_y;
      logic [MAG_W-1:0]           mag_x;
      logic [MAG_W-1:0]           mag_y;
      logic [D2_W-1:0]            d2;
      logic                       coincident;
   } item_type;

endpackage

`default_nettype wire

@@ hw/rtl/ccr_req_if.sv @@
// Request channel of the circle collision resolver: one candidate pair.
// Depends on ccr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ccr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ccr_pkg::COORD_W-1:0]   a_x;
   logic signed [ccr_pkg::COORD_W-1:0]   a_y;
   logic signed [ccr_pkg::COORD_W-1:0]   b_x;
   logic signed [ccr_pkg::COORD_W-1:0]   b_y;
   logic [ccr_pkg::RAD_W-1:0]            a_radius;
   logic [ccr_pkg::RAD_W-1:0]            b_radius;
   logic                                 a_trigger;
   logic                                 b_trigger;

   modport source (output valid, a_x, a_y, b_x, b_y, a_radius, b_radius, a_trigger,
                   b_trigger, input ready);
   modport sink (input valid, a_x, a_y, b_x, b_y, a_radius, b_radius, a_trigger,
                 b_trigger, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ccr_rsp_if.sv @@
// Response channel of the circle collision resolver: one result per pair.
// Depends on ccr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ccr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           contact_kind;
   logic signed [ccr_pkg::COORD_W-1:0]   new_a_x;
   logic signed [ccr_pkg::COORD_W-1:0]   new_a_y;
   logic signed [ccr_pkg::COORD_W-1:0]   new_b_x;
   logic signed [ccr_pkg::COORD_W-1:0]   new_b_y;
   logic signed [ccr_pkg::NORM_W-1:0]    normal_x;
   logic signed [ccr_pkg::NORM_W-1:0]    normal_y;
   logic signed [ccr_pkg::CONT_W-1:0]    contact_dx;
   logic signed [ccr_pkg::CONT_W-1:0]    contact_dy;

   modport source (output valid, contact_kind, new_a_x, new_a_y, new_b_x, new_b_y,
                   normal_x, normal_y, contact_dx, contact_dy, input ready);
   modport sink (input valid, contact_kind, new_a_x, new_a_y, new_b_x, new_b_y,
                 normal_x, normal_y, contact_dx, contact_dy, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/circle_collision_resolve.sv @@
// Top level of the circle collision resolver: front end, queue, back end.
// Depends on ccr_pkg, ccr_req_if, ccr_rsp_if, ccr_front, ccr_queue, ccr_back.
`timescale 1ns / 1ps
`default_nettype none

// Narrow-phase test and push-apart for one pair of circles per transaction.
// Fully pipelined: one pair accepted and one result delivered per cycle when
// the response side keeps up. A pair passes through two front-end stages,
// the queue slot, a seed stage, 26 square-root stages (one root bit each),
// a dividend stage, 17 divider stages for the normal (one quotient bit
// each), a multiply stage, a rounding stage and the response register.
// The queue (QueueDepth entries) absorbs the front-end stages when the
// response stalls.

module circle_collision_resolve #(
   parameter int QueueDepth = ccr_pkg::QUEUE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ccr_req_if.sink     req_ch,
   ccr_rsp_if.source   rsp_ch
);

   ccr_pkg::item_type  push_item, pop_item;
   logic               push, pop, full, empty;

   ccr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (full),
      .q_item  (push_item),
      .q_push  (push)
   );

   ccr_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty)
   );

   ccr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (empty),
      .q_item  (pop_item),
      .q_pop   (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

@@ hw/rtl/ccr_front.sv @@
// Front end: takes pairs, forms offsets and squared distance, classifies the
// contact and pushes the entry into the queue. Depends on ccr_pkg, ccr_req_if.
`timescale 1ns / 1ps
`default_nettype none

module ccr_front (
   input  wire logic          clock,
   input  wire logic          reset,
   ccr_req_if.sink            req_ch,
   input  wire logic          q_full,
   output ccr_pkg::item_type  q_item,
   output logic               q_push
);

   localparam int RsqW = 2 * ccr_pkg::RSUM_W;

   logic                                  en;
   logic                                  s1_valid_ff, s2_valid_ff;
   ccr_pkg::item_type                     s1_ff, s1_in, s2_ff;
   logic                                  s1_near_ff, s1_trig_ff, s2_near_ff, s2_trig_ff;
   logic                                  near_in;
   logic signed [ccr_pkg::COORD_W:0]      dx, dy;
   logic [ccr_pkg::COORD_W:0]             mdx, mdy;
   logic [ccr_pkg::RSUM_W-1:0]            rsum;
   logic [ccr_pkg::D2_W-1:0]              sqx_ff, sqy_ff, sqx_in, sqy_in, d2;
   logic [2*ccr_pkg::RSUM_W-1:0]          rsq_ff, rsq_in;
   logic                                  touch;

   function automatic logic [ccr_pkg::D2_W-1:0] D2W_MUL(
      input logic [ccr_pkg::MAG_W-1:0] p, input logic [ccr_pkg::MAG_W-1:0] q);
      return ccr_pkg::D2_W'(p) * ccr_pkg::D2_W'(q);
   endfunction

   // stall only when the last stage holds a transaction the queue cannot take
   assign en           = !(s2_valid_ff && q_full);
   assign req_ch.ready = en;

   // offsets, magnitudes and coarse range test
   always_comb begin
      dx   = {req_ch.a_x[31], req_ch.a_x} - {req_ch.b_x[31], req_ch.b_x};
      dy   = {req_ch.a_y[31], req_ch.a_y} - {req_ch.b_y[31], req_ch.b_y};
      mdx  = dx[ccr_pkg::COORD_W] ? 33'(-dx) : 33'(dx);
      mdy  = dy[ccr_pkg::COORD_W] ? 33'(-dy) : 33'(dy);
      rsum = {1'b0, req_ch.a_radius} + {1'b0, req_ch.b_radius};
      near_in = (mdx <= 33'(rsum)) && (mdy <= 33'(rsum));
      s1_in            = '0;
      s1_in.a_x        = req_ch.a_x;
      s1_in.a_y        = req_ch.a_y;
      s1_in.b_x        = req_ch.b_x;
      s1_in.b_y        = req_ch.b_y;
      s1_in.b_radius   = req_ch.b_radius;
      s1_in.rsum       = rsum;
      s1_in.neg_x      = dx[ccr_pkg::COORD_W];
      s1_in.neg_y      = dy[ccr_pkg::COORD_W];
      s1_in.mag_x      = mdx[ccr_pkg::MAG_W-1:0];
      s1_in.mag_y      = mdy[ccr_pkg::MAG_W-1:0];
   end

   // squares
   always_comb begin
      sqx_in = D2W_MUL(s1_ff.mag_x, s1_ff.mag_x);
      sqy_in = D2W_MUL(s1_ff.mag_y, s1_ff.mag_y);
      rsq_in = RsqW'(s1_ff.rsum) * RsqW'(s1_ff.rsum);
   end

   // classification into the queue entry
   always_comb begin
      d2    = sqx_ff + sqy_ff;
      touch = s2_near_ff && (d2 <= ccr_pkg::D2_W'(rsq_ff));
      q_item            = s2_ff;
      q_item.d2         = d2;
      q_item.coincident = (d2 == '0);
      if (!touch) begin
         q_item.kind = ccr_pkg::KIND_NONE;
      end else if (s2_trig_ff) begin
         q_item.kind = ccr_pkg::KIND_TRIGGER;
      end else begin
         q_item.kind = ccr_pkg::KIND_SOLID;
      end
      q_push = s2_valid_ff && en;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff      <= s1_in;
         s1_near_ff <= near_in;
         s1_trig_ff <= req_ch.a_trigger | req_ch.b_trigger;
         s2_ff      <= s1_ff;
         s2_near_ff <= s1_near_ff;
         s2_trig_ff <= s1_trig_ff;
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
         rsq_ff     <= rsq_in;
      end
   end

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("front pushed into a full queue");
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !en |=> s2_valid_ff) else $error("front lost a stalled transaction");
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> s1_valid_ff) else $error("accepted transaction dropped");

endmodule

`default_nettype wire

@@ hw/rtl/ccr_queue.sv @@
// Small queue between the front end and the back end.
// Depends on ccr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccr_queue #(
   parameter int Depth = ccr_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ccr_pkg::item_type  push_item,
   output logic                    full,
   input  wire logic               pop,
   output ccr_pkg::item_type       pop_item,
   output logic                    empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   ccr_pkg::item_type   mem [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]     count_ff;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign pop_item = mem[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue underflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth)) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ hw/rtl/ccr_back.sv @@
// Back end: pipelined square root, normal division, push and contact offset,
// then the response register. Depends on ccr_pkg, ccr_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module ccr_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire ccr_pkg::item_type  q_item,
   output logic                    q_pop,
   ccr_rsp_if.source               rsp_ch
);

   localparam int SqS    = ccr_pkg::SQRT_STEPS;
   localparam int DvS    = ccr_pkg::DIV_STEPS;
   localparam int PrepI  = SqS + 1;
   localparam int MulI   = PrepI + DvS + 1;
   localparam int RndI   = MulI + 1;
   localparam int Stages = RndI + 1;

   logic                                  adv;
   logic                                  valid_ff [Stages];
   ccr_pkg::item_type                     item_ff  [Stages];

   logic [ccr_pkg::D2_W-1:0]              sq_n_ff [SqS+1];
   logic [ccr_pkg::D2_W-1:0]              sq_r_ff [SqS+1];

   logic [ccr_pkg::NUM_W-1:0]             dv_rx_ff [DvS+1];
   logic [ccr_pkg::NUM_W-1:0]             dv_ry_ff [DvS+1];
   logic [ccr_pkg::QUO_W-1:0]             dv_qx_ff [DvS+1];
   logic [ccr_pkg::QUO_W-1:0]             dv_qy_ff [DvS+1];
   logic [ccr_pkg::ROOT_W-1:0]            dv_d_ff  [DvS+1];

   logic [ccr_pkg::ROOT_W-1:0]            dist_in;
   logic signed [ccr_pkg::NORM_W-1:0]     nx_in, ny_in, mu_nx_ff, mu_ny_ff, rd_nx_ff, rd_ny_ff;
   logic signed [ccr_pkg::OVL_W-1:0]      ovl_in;
   logic signed [44:0]                    mu_px_ff, mu_py_ff, px_in, py_in;
   logic signed [42:0]                    mu_kx_ff, mu_ky_ff, kx_in, ky_in;
   logic signed [33:0]                    rd_cx_ff, rd_cy_ff;
   logic signed [ccr_pkg::CONT_W-1:0]     rd_kx_ff, rd_ky_ff;

   logic                                  out_valid_ff;
   logic [1:0]                            out_kind_ff, out_kind_in;
   logic signed [ccr_pkg::COORD_W-1:0]    out_ax_ff, out_ay_ff, out_bx_ff, out_by_ff;
   logic signed [ccr_pkg::COORD_W-1:0]    out_ax_in, out_ay_in, out_bx_in, out_by_in;
   logic signed [ccr_pkg::NORM_W-1:0]     out_nx_ff, out_ny_ff, out_nx_in, out_ny_in;
   logic signed [ccr_pkg::CONT_W-1:0]     out_kx_ff, out_ky_ff, out_kx_in, out_ky_in;

   // v / 2^17 rounded to nearest, ties away from zero
   function automatic logic signed [33:0] round_q17(input logic signed [44:0] v);
      logic [44:0] m;
      m = v[44] ? 45'(-v) : 45'(v);
      m = (m + 45'(1 << 16)) >> 17;
      return v[44] ? -$signed(34'(m)) : $signed(34'(m));
   endfunction

   // v / 2^16 rounded to nearest, ties away from zero
   function automatic logic signed [ccr_pkg::CONT_W-1:0] round_q16(
      input logic signed [42:0] v);
      logic [42:0] m;
      m = v[42] ? 43'(-v) : 43'(v);
      m = (m + 43'(1 << 15)) >> 16;
      return v[42] ? -$signed(26'(m)) : $signed(26'(m));
   endfunction

   // coordinate plus push, clamped to the signed 32-bit range
   function automatic logic signed [ccr_pkg::COORD_W-1:0] sat_add(
      input logic signed [ccr_pkg::COORD_W-1:0] p, input logic signed [33:0] c);
      logic signed [34:0] s;
      s = 35'(p) + 35'(c);
      if (s > 35'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (s < -35'sd2147483648) begin
         return 32'sh80000000;
      end
      return s[31:0];
   endfunction

   // the whole back end moves together unless the response is stalled
   assign adv   = !out_valid_ff || rsp_ch.ready;
   assign q_pop = adv && !q_empty;

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Stages; i++) begin
            valid_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= !q_empty;
         for (int i = 1; i < Stages; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         out_valid_ff <= valid_ff[RndI];
      end
   end

   // entry delay line and square root seed
   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= q_item;
         for (int i = 1; i < Stages; i++) begin
            item_ff[i] <= item_ff[i-1];
         end
         sq_n_ff[0] <= q_item.d2;
         sq_r_ff[0] <= '0;
      end
   end

   // square root, one result bit per stage
   for (genvar s = 0; s < SqS; s++) begin : g_sqrt
      localparam logic [ccr_pkg::D2_W-1:0] STEP_BIT =
         ccr_pkg::D2_W'(1) << (2 * (SqS - 1 - s));
      logic [ccr_pkg::D2_W-1:0] trial, n_in, r_in;
      always_comb begin
         trial = sq_r_ff[s] + STEP_BIT;
         if (sq_n_ff[s] >= trial) begin
            n_in = sq_n_ff[s] - trial;
            r_in = (sq_r_ff[s] >> 1) + STEP_BIT;
         end else begin
            n_in = sq_n_ff[s];
            r_in = sq_r_ff[s] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_n_ff[s+1] <= n_in;
            sq_r_ff[s+1] <= r_in;
         end
      end
   end

   // distance and rounded dividends
   always_comb begin
      dist_in = item_ff[SqS].coincident ? ccr_pkg::ROOT_W'(ccr_pkg::TINY_DIST)
                                        : sq_r_ff[SqS][ccr_pkg::ROOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_d_ff[0]  <= dist_in;
         dv_rx_ff[0] <= (ccr_pkg::NUM_W'(item_ff[SqS].mag_x) << 16)
                        + ccr_pkg::NUM_W'(dist_in >> 1);
         dv_ry_ff[0] <= (ccr_pkg::NUM_W'(item_ff[SqS].mag_y) << 16)
                        + ccr_pkg::NUM_W'(dist_in >> 1);
         dv_qx_ff[0] <= '0;
         dv_qy_ff[0] <= '0;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < DvS; j++) begin : g_div
      localparam int K = DvS - 1 - j;
      logic [ccr_pkg::NUM_W-1:0] dsh, rx_in, ry_in;
      logic [ccr_pkg::QUO_W-1:0] qx_in, qy_in;
      always_comb begin
         dsh   = ccr_pkg::NUM_W'(dv_d_ff[j]) << K;
         rx_in = dv_rx_ff[j];
         ry_in = dv_ry_ff[j];
         qx_in = dv_qx_ff[j];
         qy_in = dv_qy_ff[j];
         if (dv_rx_ff[j] >= dsh) begin
            rx_in = dv_rx_ff[j] - dsh;
            qx_in = dv_qx_ff[j] | (ccr_pkg::QUO_W'(1) << K);
         end
         if (dv_ry_ff[j] >= dsh) begin
            ry_in = dv_ry_ff[j] - dsh;
            qy_in = dv_qy_ff[j] | (ccr_pkg::QUO_W'(1) << K);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_d_ff[j+1]  <= dv_d_ff[j];
            dv_rx_ff[j+1] <= rx_in;
            dv_ry_ff[j+1] <= ry_in;
            dv_qx_ff[j+1] <= qx_in;
            dv_qy_ff[j+1] <= qy_in;
         end
      end
   end

   // signed normal, overlap and the two products
   always_comb begin
      if (item_ff[MulI-1].coincident) begin
         nx_in = ccr_pkg::NORM_W'(ccr_pkg::Q_ONE);
         ny_in = '0;
      end else begin
         nx_in = item_ff[MulI-1].neg_x ? -$signed({1'b0, dv_qx_ff[DvS]})
                                       : $signed({1'b0, dv_qx_ff[DvS]});
         ny_in = item_ff[MulI-1].neg_y ? -$signed({1'b0, dv_qy_ff[DvS]})
                                       : $signed({1'b0, dv_qy_ff[DvS]});
      end
      ovl_in = $signed({2'b00, item_ff[MulI-1].rsum}) - $signed({1'b0, dv_d_ff[DvS]});
      px_in  = 45'(nx_in) * 45'(ovl_in);
      py_in  = 45'(ny_in) * 45'(ovl_in);
      kx_in  = 43'(nx_in) * 43'($signed({1'b0, item_ff[MulI-1].b_radius}));
      ky_in  = 43'(ny_in) * 43'($signed({1'b0, item_ff[MulI-1].b_radius}));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mu_nx_ff <= nx_in;
         mu_ny_ff <= ny_in;
         mu_px_ff <= px_in;
         mu_py_ff <= py_in;
         mu_kx_ff <= kx_in;
         mu_ky_ff <= ky_in;
         rd_nx_ff <= mu_nx_ff;
         rd_ny_ff <= mu_ny_ff;
         rd_cx_ff <= round_q17(mu_px_ff);
         rd_cy_ff <= round_q17(mu_py_ff);
         rd_kx_ff <= round_q16(mu_kx_ff);
         rd_ky_ff <= round_q16(mu_ky_ff);
      end
   end

   // response assembly
   always_comb begin
      out_kind_in = item_ff[RndI].kind;
      out_ax_in   = item_ff[RndI].a_x;
      out_ay_in   = item_ff[RndI].a_y;
      out_bx_in   = item_ff[RndI].b_x;
      out_by_in   = item_ff[RndI].b_y;
      out_nx_in   = '0;
      out_ny_in   = '0;
      out_kx_in   = '0;
      out_ky_in   = '0;
      if (item_ff[RndI].kind == ccr_pkg::KIND_SOLID) begin
         out_ax_in = sat_add(item_ff[RndI].a_x, rd_cx_ff);
         out_ay_in = sat_add(item_ff[RndI].a_y, rd_cy_ff);
         out_bx_in = sat_add(item_ff[RndI].b_x, -rd_cx_ff);
         out_by_in = sat_add(item_ff[RndI].b_y, -rd_cy_ff);
         out_nx_in = rd_nx_ff;
         out_ny_in = rd_ny_ff;
         out_kx_in = rd_kx_ff;
         out_ky_in = rd_ky_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_kind_ff <= out_kind_in;
         out_ax_ff   <= out_ax_in;
         out_ay_ff   <= out_ay_in;
         out_bx_ff   <= out_bx_in;
         out_by_ff   <= out_by_in;
         out_nx_ff   <= out_nx_in;
         out_ny_ff   <= out_ny_in;
         out_kx_ff   <= out_kx_in;
         out_ky_ff   <= out_ky_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.contact_kind = out_kind_ff;
   assign rsp_ch.new_a_x      = out_ax_ff;
   assign rsp_ch.new_a_y      = out_ay_ff;
   assign rsp_ch.new_b_x      = out_bx_ff;
   assign rsp_ch.new_b_y      = out_by_ff;
   assign rsp_ch.normal_x     = out_nx_ff;
   assign rsp_ch.normal_y     = out_ny_ff;
   assign rsp_ch.contact_dx   = out_kx_ff;
   assign rsp_ch.contact_dy   = out_ky_ff;

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff != ccr_pkg::KIND_SOLID |->
         out_nx_ff == '0 && out_ny_ff == '0 && out_kx_ff == '0 && out_ky_ff == '0)
      else $error("normal or contact set without a solid contact");
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == ccr_pkg::KIND_SOLID |->
         out_nx_ff <= 18'sd65536 && out_nx_ff >= -18'sd65536 &&
         out_ny_ff <= 18'sd65536 && out_ny_ff >= -18'sd65536)
      else $error("normal out of unit range");
   a_tail_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[RndI] && !adv |=> valid_ff[RndI])
      else $error("back end lost a stalled transaction");

endmodule

`default_nettype wire
